[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/sha512_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-512 package
// Constants, round table and round functions shared by the hasher.
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam int unsigned BlockBytes = 128;
  localparam int unsigned Rounds     = 80;
  localparam int unsigned Words      = 16;

  typedef logic [63:0] word_t;

  typedef enum logic [0:0] {
    KIND_ABSORB = 1'b0,
    KIND_FINISH = 1'b1
  } kind_t;

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      3'd7: r = 64'h5be0cd19137e2179;
      default: r = '0;
    endcase
    return r;
  endfunction

  localparam word_t RoundK [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t ssig0(input word_t x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  // control from the sequencer to the round core
  typedef struct packed {
    logic       load;
    logic       shift_in;
    logic       round;
    logic       fold;
    logic [6:0] rnd;
  } core_ctl_t;

endpackage

[hw/rtl/sha512_core.sv]
// ----------------------------------------------------------------------------
// SHA-512 round core
// Hash state, rolling schedule and one shared round datapath per cycle.
// ----------------------------------------------------------------------------
module sha512_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha512_pkg::core_ctl_t ctl,
  input  sha512_pkg::word_t     word_in,
  input  logic                  reinit,
  input  logic [2:0]            rd_idx,
  output sha512_pkg::word_t     rd_word
);
  import sha512_pkg::*;

  word_t h_r   [8];
  word_t h_nxt [8];
  word_t v_r   [8];
  word_t v_nxt [8];
  word_t w_r   [Words];
  word_t w_nxt [Words];
  word_t w_new;
  word_t t1;
  word_t t2;
  logic  sched_gen;

  assign sched_gen = ctl.rnd >= 7'd16;
  assign w_new = sched_gen ? (w_r[0] + ssig0(w_r[1]) + w_r[9] + ssig1(w_r[14])) : w_r[0];
  assign t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + RoundK[ctl.rnd] + w_new;
  assign t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign rd_word = h_r[rd_idx];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      h_nxt[i] = h_r[i];
      v_nxt[i] = v_r[i];
    end
    for (int i = 0; i < Words; i++) w_nxt[i] = w_r[i];
    if (ctl.shift_in) begin
      for (int i = 0; i < Words - 1; i++) w_nxt[i] = w_r[i + 1];
      w_nxt[Words - 1] = word_in;
    end
    if (ctl.load) begin
      for (int i = 0; i < 8; i++) v_nxt[i] = h_r[i];
    end
    if (ctl.round) begin
      for (int i = 0; i < Words - 1; i++) w_nxt[i] = w_r[i + 1];
      w_nxt[Words - 1] = w_new;
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
    if (ctl.fold) begin
      for (int i = 0; i < 8; i++) h_nxt[i] = h_r[i] + v_r[i];
    end
    if (reinit) begin
      for (int i = 0; i < 8; i++) h_nxt[i] = init_hash(3'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
    end else begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_nxt[i];
    end
    for (int i = 0; i < 8; i++) v_r[i] <= v_nxt[i];
    for (int i = 0; i < Words; i++) w_r[i] <= w_nxt[i];
  end

endmodule

[hw/rtl/sha512_stream_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-512 stream hasher
// Byte-stream absorber, padding sequencer and iterative round engine.
// ----------------------------------------------------------------------------
// channel | dir | tdata                     | tuser | tlast
// in_     | in  | data_bytes, byte_count    | kind  | -
// out_    | out | digest_word, word_index   | -     | last
// An absorb that does not fill the block leaves the hasher idle; a full block
// then runs the load, round and fold states in turn (one round per cycle).
// Finish writes the 0x80 word, then the pad state writes the remaining zero and
// length words; it runs one or two padded blocks, then delivers eight words.
// in_tready is low while a block is padded or compresses or the digest is delivered.
// Reset is synchronous active low and restores the initial hash values.
module sha512_stream_hasher (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // data_bytes[63:0], byte_count[67:64], zeros
  input  logic         in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // digest_word[63:0], word_index[66:64], zeros
  output logic         out_tlast
);
  import sha512_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_FOLD  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] buf_r [Words];
  logic [63:0] buf_nxt [Words];
  logic [63:0] w0_r, w0_nxt;
  logic [6:0]  fill_r, fill_nxt;
  logic [60:0] total_r, total_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        fin_r, fin_nxt;
  logic [1:0]  pad_r, pad_nxt;   // 1: pad to end, 2: length block
  logic [2:0]  oidx_r, oidx_nxt;
  logic [63:0] bits_r, bits_nxt;
  core_ctl_t   ctl;
  logic        reinit;
  word_t       rd_word;
  logic [3:0]  cnt_in;
  logic        in_xfer;
  logic [7:0]  byte_v;
  logic [7:0]  bsel;
  logic [6:0]  pos;

  assign in_tready = state_r == ST_IDLE;
  assign in_xfer   = in_tvalid && in_tready;
  assign cnt_in    = (in_tdata[67:64] > 4'd8) ? 4'd8 : in_tdata[67:64];
  assign out_tvalid = state_r == ST_OUT;
  assign out_tdata  = {5'd0, oidx_r, rd_word};
  assign out_tlast  = oidx_r == 3'd7;

  sha512_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .word_in ((cnt_r == 7'd0) ? w0_r : buf_r[cnt_r[3:0]]),
    .reinit  (reinit),
    .rd_idx  (oidx_r),
    .rd_word (rd_word)
  );

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    total_nxt = total_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    pad_nxt   = pad_r;
    oidx_nxt  = oidx_r;
    bits_nxt  = bits_r;
    for (int i = 0; i < Words; i++) buf_nxt[i] = buf_r[i];
    ctl       = '0;
    ctl.rnd   = cnt_r;
    reinit    = 1'b0;
    byte_v    = '0;
    bsel      = '0;
    pos       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == KIND_FINISH) begin
            bits_nxt = {total_r, 3'b000};
            fin_nxt  = 1'b1;
            pos = fill_r;
            buf_nxt[pos[6:3]][8 * (7 - pos[2:0]) +: 8] = 8'h80;
            for (int j = 0; j < 8; j++) begin
              if (3'(j) > pos[2:0]) buf_nxt[pos[6:3]][8 * (7 - j) +: 8] = 8'h00;
            end
            fill_nxt = {pos[6:3] + 4'd1, 3'b000};
            pad_nxt  = 2'd0;
            state_nxt = (pos[6:3] == 4'd15) ? ST_LOAD : ST_PAD;
            cnt_nxt  = '0;
          end else begin
            for (int j = 0; j < 8; j++) begin
              pos = fill_r + 7'(j);
              byte_v = in_tdata[8 * (7 - j) +: 8];
              if (4'(j) < cnt_in) buf_nxt[pos[6:3]][8 * (7 - pos[2:0]) +: 8] = byte_v;
            end
            fill_nxt  = fill_r + 7'(cnt_in);
            total_nxt = total_r + 61'(cnt_in);
            if ({1'b0, fill_r} + 8'(cnt_in) >= 8'(BlockBytes)) begin
              fin_nxt   = 1'b0;
              state_nxt = ST_LOAD;
              cnt_nxt   = '0;
            end
          end
        end
      end
      ST_PAD: begin
        // zero words, length word at the end of the block
        bsel = {1'b0, fill_r};
        if (fill_r[6:3] == 4'd15) buf_nxt[15] = (pad_r == 2'd1) ? 64'd0 : bits_r;
        else if (fill_r[6:3] == 4'd14) buf_nxt[14] = '0;
        else buf_nxt[fill_r[6:3]] = '0;
        if (fill_r[6:3] == 4'd15 || (fill_r == 7'd0 && pad_r == 2'd0 && bsel[7])) begin
          state_nxt = ST_LOAD;
          cnt_nxt = '0;
        end
        fill_nxt = fill_r + 7'd8;
      end
      ST_LOAD: begin
        ctl.shift_in = 1'b1;
        if (cnt_r == 7'd15) begin
          ctl.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_ROUND;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      ST_ROUND: begin
        ctl.round = 1'b1;
        if (cnt_r == 7'(Rounds - 1)) state_nxt = ST_FOLD;
        cnt_nxt = cnt_r + 7'd1;
      end
      ST_FOLD: begin
        ctl.fold = 1'b1;
        cnt_nxt  = '0;
        if (!fin_r) state_nxt = ST_IDLE;
        else if (pad_r == 2'd1) begin
          pad_nxt = 2'd2;
          state_nxt = ST_PAD;
        end else if (pad_r == 2'd2) begin
          oidx_nxt = '0;
          state_nxt = ST_OUT;
        end else begin
          // block with 0x80 filled the whole buffer: length goes in a new block
          pad_nxt = 2'd2;
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            reinit    = 1'b1;
            fill_nxt  = '0;
            total_nxt = '0;
            fin_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // in padding, length fits only when the 0x80 word left room for two words
    if (state_r == ST_IDLE && in_xfer && in_tuser == KIND_FINISH) begin
      pad_nxt = (fill_r[6:3] >= 4'd14) ? 2'd1 : 2'd2;
      if (fill_r[6:3] == 4'd15) pad_nxt = 2'd0;
    end
    // hold the first block word; bytes past the block end land in word 0
    w0_nxt = (state_r == ST_LOAD) ? w0_r : buf_nxt[0];
    if (state_r == ST_IDLE && in_xfer && in_tuser == KIND_ABSORB) w0_nxt = buf_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      total_r <= '0;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
      pad_r   <= '0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
      pad_r   <= pad_nxt;
      oidx_r  <= oidx_nxt;
    end
    bits_r <= bits_nxt;
    w0_r   <= w0_nxt;
    for (int i = 0; i < Words; i++) buf_r[i] <= buf_nxt[i];
  end

endmodule

[hw/rtl/sha512_checker.sv]
// ----------------------------------------------------------------------------
// SHA-512 port checker
// Port-level checks on the hasher's stream channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha512_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast
);
  `ASSERT_IMPLY(a_no_overlap, clk, rst_n, out_tvalid, !in_tready)
  `ASSERT_IMPLY(a_last_idx, clk, rst_n, out_tvalid, out_tlast == (out_tdata[66:64] == 3'd7))
  `ASSERT_NEXT(a_idx_step, clk, rst_n, out_tvalid && out_tready && !out_tlast,
               out_tvalid && out_tdata[66:64] == $past(out_tdata[66:64]) + 3'd1)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind sha512_stream_hasher sha512_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[dv/tb_sha512_stream_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-512 stream hasher testbench
// Streams message bytes and finish commands into the hasher, predicts each
// digest with a behavioral SHA-512 and compares every delivered word.
// ----------------------------------------------------------------------------
module tb_sha512_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;
  import sha512_pkg::*;

  typedef struct {
    word_t      digest_word;
    logic [2:0] word_index;
    logic       last;
  } digest_beat_t;

  class digest_scoreboard;
    word_t          chain [8];
    logic [7:0]     msg_buf [BlockBytes];
    int unsigned    fill;
    logic [60:0]    length_bytes;
    digest_beat_t   pending_words [$];
    int unsigned    errors;

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = init_hash(3'(i));
      fill = 0;
      length_bytes = '0;
    endfunction

    function word_t ror(word_t x, int unsigned n);
      return (x >> n) | (x << (64 - n));
    endfunction

    function void compress();
      word_t w [16];
      word_t v [8];
      word_t t1, t2, s0, s1;
      for (int t = 0; t < 16; t++)
        for (int i = 0; i < 8; i++) w[t] = {w[t][55:0], msg_buf[t * 8 + i]};
      v = chain;
      for (int t = 0; t < Rounds; t++) begin
        if (t >= 16) begin
          s1 = ror(w[(t - 2) & 15], 19) ^ ror(w[(t - 2) & 15], 61) ^ (w[(t - 2) & 15] >> 6);
          s0 = ror(w[(t - 15) & 15], 1) ^ ror(w[(t - 15) & 15], 8) ^ (w[(t - 15) & 15] >> 7);
          w[t & 15] = w[t & 15] + s1 + w[(t - 7) & 15] + s0;
        end
        t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t & 15];
        t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void append(logic [7:0] b);
      msg_buf[fill] = b;
      fill++;
      if (fill == BlockBytes) begin
        compress();
        fill = 0;
      end
    endfunction

    function void note_input(kind_t kind, word_t data, logic [3:0] cnt);
      int unsigned n;
      logic [63:0] bits;
      digest_beat_t beat;
      if (kind == KIND_ABSORB) begin
        n = (cnt > 8) ? 8 : cnt;
        for (int i = 0; i < n; i++) append(data[63 - 8 * i -: 8]);
        length_bytes += 61'(n);
      end else begin
        bits = {length_bytes, 3'b000};
        append(8'h80);
        if (fill > BlockBytes - 16) while (fill != 0) append(8'h00);
        while (fill < BlockBytes - 8) append(8'h00);
        for (int i = 0; i < 8; i++) append(bits[63 - 8 * i -: 8]);
        for (int i = 0; i < 8; i++) begin
          beat.digest_word = chain[i];
          beat.word_index = 3'(i);
          beat.last = (i == 7);
          pending_words.push_back(beat);
        end
        restart();
      end
    endfunction

    function void check_word(word_t dw, logic [2:0] idx, logic lst);
      digest_beat_t e;
      if (pending_words.size() == 0) begin
        $error("unexpected digest word %h", dw);
        errors++;
        return;
      end
      e = pending_words.pop_front();
      if (dw !== e.digest_word) begin
        $error("digest_word expected %h actual %h", e.digest_word, dw);
        errors++;
      end
      if (idx !== e.word_index) begin
        $error("word_index expected %0d actual %0d", e.word_index, idx);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last expected %0b actual %0b", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned IdleLimit = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tlast;

  digest_scoreboard sb = new();
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  bit          sink_hold = 1'b0;
  int unsigned quiet_cycles = 0;

  sha512_stream_hasher dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(out_tdata[63:0], out_tdata[66:64], out_tlast);
    if (rst_n && (in_tvalid && in_tready || out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= rst_n && !sink_hold && ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_item(kind_t kind, word_t data, logic [3:0] cnt);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'h0, cnt, data};
    do @(posedge clk); while (!in_tready);
    sb.note_input(kind, data, cnt);
  endtask

  task automatic send_message(int unsigned items);
    for (int i = 0; i < items; i++)
      send_item(KIND_ABSORB, {$urandom, $urandom},
                ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd8);
    send_item(KIND_FINISH, {$urandom, $urandom}, 4'($urandom_range(15)));
  endtask

  task automatic drain();
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb.restart();
    sb.errors = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(KIND_FINISH, '0, 4'd0);
    send_item(KIND_ABSORB, 64'h6162_6300_0000_0000, 4'd3);
    send_item(KIND_FINISH, '1, 4'd15);
    send_item(KIND_ABSORB, '1, 4'd8);
    send_item(KIND_ABSORB, '1, 4'd0);
    send_item(KIND_ABSORB, 64'h0123_4567_89ab_cdef, 4'd15);
    send_item(KIND_ABSORB, '0, 4'd9);
    send_item(KIND_ABSORB, 64'h8000_0000_0000_0001, 4'd1);
    send_item(KIND_FINISH, '0, 4'd0);
    for (int i = 0; i < 14; i++) send_item(KIND_ABSORB, {$urandom, $urandom}, 4'd8);
    send_item(KIND_ABSORB, '1, 4'd7);
    send_item(KIND_FINISH, '0, 4'd0);
    in_tvalid <= 1'b0;
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      src_idle_pct   = (phase == 1 || phase == 3) ? ((phase == 3) ? 14 : 69) : 0;
      sink_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 14 : 69) : 0;
      send_message($urandom_range(12));
      send_message($urandom_range(3));
      send_message($urandom_range(12, 20));
    end

    fork
      begin
        sink_hold = 1'b1;
        repeat (400) @(posedge clk);
        sink_hold = 1'b0;
      end
      begin
        send_message(2);
        send_message(1);
        in_tvalid <= 1'b0;
      end
    join
    drain();
    send_message(16);
    in_tvalid <= 1'b0;
    drain();

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/sha512_pkg.sv
hw/rtl/sha512_core.sv
hw/rtl/sha512_stream_hasher.sv
hw/rtl/sha512_checker.sv
dv/tb_sha512_stream_hasher.sv
